/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the heat index block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define HIC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs during reset
`define HIC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/hic_pkg.sv */
// Package for the heat index calculator: field widths, fixed-point constants,
// regression coefficients, reciprocals and the rounding/saturation helpers.
// No dependencies.
package hic_pkg;

    // Port field widths
    localparam int TEMP_W = 16;
    localparam int RH_W   = 15;
    localparam int OUT_W  = 20;

    // Q.16 constants
    localparam longint ONE16 = 64'sd65536;
    localparam longint C13 = 13 * ONE16;
    localparam longint C17 = 17 * ONE16;
    localparam longint C32 = 32 * ONE16;
    localparam longint C61 = 61 * ONE16;
    localparam longint C68 = 68 * ONE16;
    localparam longint C80 = 80 * ONE16;
    localparam longint C85 = 85 * ONE16;
    localparam longint C87 = 87 * ONE16;
    localparam longint C95 = 95 * ONE16;
    localparam longint C110 = 110 * ONE16;

    // Regression coefficients rounded to nearest: K_C in Q.16, the others in Q.32
    localparam longint Q32 = 64'sd4294967296;
    localparam longint QDEN = 64'sd100000000;
    localparam longint QHALF = 64'sd50000000;
    localparam longint K_C    = (64'sd42379 * ONE16 + 64'sd500) / 64'sd1000;
    localparam longint K_F    = (64'sd204901523 * Q32 + QHALF) / QDEN;
    localparam longint K_H    = (64'sd1014333127 * Q32 + QHALF) / QDEN;
    localparam longint K_FH   = (64'sd22475541 * Q32 + QHALF) / QDEN;
    localparam longint K_F2   = (64'sd683783 * Q32 + QHALF) / QDEN;
    localparam longint K_H2   = (64'sd5481717 * Q32 + QHALF) / QDEN;
    localparam longint K_F2H  = (64'sd122874 * Q32 + QHALF) / QDEN;
    localparam longint K_FH2  = (64'sd85282 * Q32 + QHALF) / QDEN;
    localparam longint K_F2H2 = (64'sd199 * Q32 + QHALF) / QDEN;

    // Reciprocals for exact floor division by small constants
    localparam longint R5   = 64'sd3435973837;   // x/5   = x*R5 >> 34,   x < 2^32
    localparam longint R17  = 64'sd3947581;      // x/17  = x*R17 >> 26,  x < 2^21
    localparam longint R25  = 64'sd42949673;     // x/25  = x*R25 >> 30,  x < 2^25
    localparam longint R125 = 64'sd137438954;    // x/125 = x*R125 >> 34, x < 2^27
    localparam longint R9   = 64'sd30541989661;  // x/9   = x*R9 >> 38,   x < 2^34

    localparam longint OUT_MAX = 64'sd524287;
    localparam longint OUT_MIN = -64'sd524288;

    // Shift right by sh, rounding half away from zero
    function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                               input int unsigned sh);
        return (v + (64'sd1 <<< (sh - 1)) - (v[63] ? 64'sd1 : 64'sd0)) >>> sh;
    endfunction

    // Clamp to the signed output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (c > OUT_MAX) c = OUT_MAX;
        if (c < OUT_MIN) c = OUT_MIN;
        return OUT_W'(c);
    endfunction

endpackage

/* hdl/heat_index_calculator.sv */
// Heat index calculator top level: 14-stage pipeline from Celsius and humidity to
// temperature and heat index in the selected unit. Depends on hic_pkg.
//
// Accepts one sample per clock while the input is not stalled, and returns results
// in order through the register pipeline, whose length is set mostly by the chained
// monomial products and the three-stage square root of the low-humidity correction.
// Idle stages close up behind a stalled output, so the input keeps taking samples
// until all 14 stages are full. The single configuration bit selects Fahrenheit (1)
// or Celsius (0) results, resets to Celsius, and is sampled as each sample enters.
module heat_index_calculator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_data,
    output logic                               o_cfg_ready,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [hic_pkg::TEMP_W-1:0]  i_temp_celsius,
    input  logic        [hic_pkg::RH_W-1:0]    i_rel_humidity,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [hic_pkg::OUT_W-1:0]   o_temp_out,
    output logic signed [hic_pkg::OUT_W-1:0]   o_hindex
);
    import hic_pkg::*;

    localparam int NSTG = 14;

    typedef struct packed {
        logic [18:0] rem;
        logic [16:0] root;
        logic [33:0] x;
    } t_sq;

    typedef struct packed {
        logic               unit;
        logic signed [15:0] tc;
        logic signed [23:0] h;
        logic               neg;
        logic [26:0]        y;
        logic [23:0]        q;
        logic signed [25:0] f;
        logic signed [34:0] f2;
        logic signed [31:0] h2;
        logic signed [33:0] fh;
        logic signed [41:0] f2h;
        logic signed [40:0] fh2;
        logic signed [48:0] f2h2;
        logic signed [32:0] t_f;
        logic signed [32:0] t_h;
        logic signed [32:0] t_fh;
        logic signed [32:0] t_f2;
        logic signed [32:0] t_h2;
        logic signed [32:0] t_f2h;
        logic signed [32:0] t_fh2;
        logic signed [32:0] t_f2h2;
        logic signed [34:0] psum;
        logic               lo_c;
        logic               hh_c;
        logic               st_c;
        logic [20:0]        num;
        logic [19:0]        ha;
        logic [21:0]        hb_a;
        logic [18:0]        hb_b;
        logic [16:0]        nd17;
        logic [32:0]        r;
        t_sq                sq;
        logic [19:0]        lo;
        logic [40:0]        hh_p;
        logic [20:0]        hh;
        logic               st_neg;
        logic [26:0]        st_m;
        logic [29:0]        st_b;
        logic [24:0]        st_q5;
        logic [19:0]        st_q1000;
        logic signed [26:0] st_hi;
        logic signed [32:0] hi;
        logic               cv_neg;
        logic [34:0]        cv_m;
        logic signed [32:0] c_hi;
        logic signed [19:0] tout;
        logic signed [19:0] hout;
    } t_pipe;

    // One digit-by-digit square root step
    function automatic t_sq sq_step(input t_sq a);
        t_sq         b;
        logic [20:0] trem;
        logic [20:0] trial;
        trem  = {a.rem, a.x[33:32]};
        trial = {2'b00, a.root, 2'b01};
        b.x   = {a.x[31:0], 2'b00};
        if (trem >= trial) begin
            b.rem  = 19'(trem - trial);
            b.root = {a.root[15:0], 1'b1};
        end else begin
            b.rem  = 19'(trem);
            b.root = {a.root[15:0], 1'b0};
        end
        return b;
    endfunction

    logic            r_unit;
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] stg_en;
    t_pipe           r_s [NSTG];
    t_pipe           n_s [NSTG];

    // Unit register, written through the configuration channel
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_unit <= i_cfg_data;
        end
    end

    // Stage enables: a stage loads when it is empty or the next one loads
    assign stg_en[NSTG-1] = !r_v[NSTG-1] || !i_out_stall;
    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign stg_en[k] = !r_v[k] || stg_en[k+1];
    end

    assign o_in_stall = !stg_en[0];

    // Datapath of all stages
    always_comb begin
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] p3;
        logic signed [63:0] p4;
        logic signed [63:0] fd;
        logic [71:0]        w9;
        logic [16:0]        tc_mag;
        t_sq                sq;

        // Stage 0: capture and scale |Tc| by 9*256
        n_s[0]      = r_s[0];
        n_s[0].unit = r_unit;
        n_s[0].tc   = i_temp_celsius;
        n_s[0].h    = {1'b0, i_rel_humidity, 8'd0};
        n_s[0].neg  = i_temp_celsius[15];
        tc_mag = i_temp_celsius[15] ? 17'(-17'(i_temp_celsius)) : 17'(i_temp_celsius);
        n_s[0].y = 27'({tc_mag, 11'd0}) + 27'({tc_mag, 8'd0}) + 27'd2;

        // Stage 1: divide by 5
        n_s[1]   = r_s[0];
        p0       = 64'(r_s[0].y) * R5;
        n_s[1].q = 24'(p0 >> 34);

        // Stage 2: restore sign, add 32 F
        n_s[2] = r_s[1];
        fd     = 64'(r_s[1].q);
        if (r_s[1].neg) fd = -fd;
        n_s[2].f = 26'(fd + C32);

        // Stage 3: first products, case flags, correction operands
        n_s[3]     = r_s[2];
        p0         = 64'(r_s[2].f) * 64'(r_s[2].f);
        n_s[3].f2  = 35'(rnd(p0, 16));
        p1         = 64'(r_s[2].h) * 64'(r_s[2].h);
        n_s[3].h2  = 32'(rnd(p1, 16));
        p2         = 64'(r_s[2].f) * 64'(r_s[2].h);
        n_s[3].fh  = 34'(rnd(p2, 16));
        p3         = K_F * 64'(r_s[2].f);
        n_s[3].t_f = 33'(rnd(p3, 32));
        p4         = K_H * 64'(r_s[2].h);
        n_s[3].t_h = 33'(rnd(p4, 32));
        n_s[3].lo_c = (64'(r_s[2].h) < C13) && (64'(r_s[2].f) >= C80)
                      && (64'(r_s[2].f) <= C110);
        n_s[3].hh_c = !n_s[3].lo_c && (64'(r_s[2].h) > C85) && (64'(r_s[2].f) > C80)
                      && (64'(r_s[2].f) < C87);
        n_s[3].st_c = !n_s[3].lo_c && !n_s[3].hh_c && (64'(r_s[2].f) < C80);
        fd = 64'(r_s[2].f) - C95;
        if (fd[63]) fd = -fd;
        n_s[3].num    = 21'(C17 - fd);
        n_s[3].ha     = 20'(C13 - 64'(r_s[2].h));
        n_s[3].hb_a   = 22'(64'(r_s[2].h) - C85);
        n_s[3].hb_b   = 19'(C87 - 64'(r_s[2].f));
        p0            = 64'sd6 * (64'(r_s[2].f) - C68);
        n_s[3].st_neg = p0[63];
        n_s[3].st_m   = 27'((p0[63] ? -p0 : p0) + 64'sd2);
        n_s[3].st_b   = 30'(64'sd94 * 64'(r_s[2].h));

        // Stage 4: second products, first terms, partial sum
        n_s[4]      = r_s[3];
        p0          = 64'(r_s[3].f2) * 64'(r_s[3].h);
        n_s[4].f2h  = 42'(rnd(p0, 16));
        p1          = 64'(r_s[3].f) * 64'(r_s[3].h2);
        n_s[4].fh2  = 41'(rnd(p1, 16));
        p2          = 64'(r_s[3].f2) * 64'(r_s[3].h2);
        n_s[4].f2h2 = 49'(rnd(p2, 16));
        n_s[4].t_fh = 33'(rnd(K_FH * 64'(r_s[3].fh), 32));
        n_s[4].t_f2 = 33'(rnd(K_F2 * 64'(r_s[3].f2), 32));
        n_s[4].t_h2 = 33'(rnd(K_H2 * 64'(r_s[3].h2), 32));
        n_s[4].psum = 35'(64'(r_s[3].t_f) + 64'(r_s[3].t_h) - K_C);
        n_s[4].nd17 = 17'((64'(r_s[3].num) * R17) >> 26);
        n_s[4].hh_p = 41'(64'(r_s[3].hb_a) * 64'(r_s[3].hb_b));
        n_s[4].st_q5 = 25'((64'(r_s[3].st_m) * R5) >> 34);
        n_s[4].st_q1000 = 20'((((64'(r_s[3].st_b) + 64'sd500) >> 3) * R125) >> 34);

        // Stage 5: last terms, sqrt operand, high-humidity and Steadman values
        n_s[5]        = r_s[4];
        n_s[5].t_f2h  = 33'(rnd(K_F2H * 64'(r_s[4].f2h), 32));
        n_s[5].t_fh2  = 33'(rnd(K_FH2 * 64'(r_s[4].fh2), 32));
        n_s[5].t_f2h2 = 33'(rnd(K_F2H2 * 64'(r_s[4].f2h2), 32));
        n_s[5].psum = 35'(64'(r_s[4].psum) - 64'(r_s[4].t_fh) - 64'(r_s[4].t_f2)
                          - 64'(r_s[4].t_h2));
        n_s[5].r  = 33'(64'(r_s[4].num) * 64'sd3855 + 64'(r_s[4].nd17));
        n_s[5].hh = 21'((((64'(r_s[4].hh_p) + 64'sd1638400) >> 17) * R25) >> 30);
        fd = 64'(r_s[4].st_q5);
        if (r_s[4].st_neg) fd = -fd;
        n_s[5].st_hi = 27'(rnd(64'(r_s[4].f) + C61 + fd + 64'(r_s[4].st_q1000), 1));

        // Stage 6: regression sum, square root steps 1 to 6
        n_s[6] = r_s[5];
        n_s[6].psum = 35'(64'(r_s[5].psum) + 64'(r_s[5].t_f2h) + 64'(r_s[5].t_fh2)
                          - 64'(r_s[5].t_f2h2));
        sq.rem  = '0;
        sq.root = '0;
        sq.x    = {1'b0, r_s[5].r};
        for (int i = 0; i < 6; i++) sq = sq_step(sq);
        n_s[6].sq = sq;

        // Stage 7: square root steps 7 to 12
        n_s[7] = r_s[6];
        sq     = r_s[6].sq;
        for (int i = 0; i < 6; i++) sq = sq_step(sq);
        n_s[7].sq = sq;

        // Stage 8: square root steps 13 to 17
        n_s[8] = r_s[7];
        sq     = r_s[7].sq;
        for (int i = 0; i < 5; i++) sq = sq_step(sq);
        n_s[8].sq = sq;

        // Stage 9: low-humidity correction
        n_s[9]    = r_s[8];
        n_s[9].lo = 20'((64'(r_s[8].ha) * 64'(r_s[8].sq.root) + 64'sd131072) >> 18);

        // Stage 10: apply the case that holds
        n_s[10] = r_s[9];
        priority if (r_s[9].lo_c) begin
            fd = 64'(r_s[9].psum) - 64'(r_s[9].lo);
        end else if (r_s[9].hh_c) begin
            fd = 64'(r_s[9].psum) + 64'(r_s[9].hh);
        end else if (r_s[9].st_c) begin
            fd = 64'(r_s[9].st_hi);
        end else begin
            fd = 64'(r_s[9].psum);
        end
        n_s[10].hi = 33'(fd);

        // Stage 11: Celsius numerator
        n_s[11]        = r_s[10];
        p0             = 64'sd5 * (64'(r_s[10].hi) - C32);
        n_s[11].cv_neg = p0[63];
        n_s[11].cv_m   = 35'((p0[63] ? -p0 : p0) + 64'sd4);

        // Stage 12: divide by 9
        n_s[12] = r_s[11];
        w9      = 72'(r_s[11].cv_m) * 72'(R9);
        fd      = 64'(35'(w9 >> 38));
        if (r_s[11].cv_neg) fd = -fd;
        n_s[12].c_hi = 33'(fd);

        // Stage 13: select unit, round to Q.8, saturate
        n_s[13] = r_s[12];
        fd      = r_s[12].unit ? 64'(r_s[12].hi) : 64'(r_s[12].c_hi);
        n_s[13].hout = sat_out(rnd(fd, 8));
        n_s[13].tout = r_s[12].unit ? sat_out(rnd(64'(r_s[12].f), 8))
                                    : sat_out(64'(r_s[12].tc));
    end

    // Stage registers: valid bits reset, payload only loads
    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (stg_en[k]) begin
                if (k == 0) begin
                    r_v[k] <= i_in_valid;
                end else begin
                    r_v[k] <= r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_en[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_out_valid  = r_v[NSTG-1];
    assign o_temp_out   = r_s[NSTG-1].tout;
    assign o_hindex     = r_s[NSTG-1].hout;

endmodule

/* hdl/hic_checker.sv */
// Port-level checker for the heat index calculator, bound to its top level.
// Depends on hic_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hic_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [hic_pkg::OUT_W-1:0]  o_temp_out,
    input logic signed [hic_pkg::OUT_W-1:0]  o_hindex
);
    // Reset empties the pipeline
    `HIC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // Hold a stalled result
    `HIC_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_temp_out) && $stable(o_hindex), "stalled result changed")

    // Input stalls only when the pipeline is full behind a stalled output
    `HIC_ASSERT(a_in_stall, o_in_stall |-> o_out_valid && i_out_stall, "input stalled with room left")

endmodule

bind heat_index_calculator hic_checker u_hic_checker (.*);

/* tb/heat_index_calculator_tb.sv */
// Self-checking testbench for heat_index_calculator: directed table, then random
// samples across idling phases, each result checked against a fixed-point predictor.
// Depends on hic_pkg and the heat_index_calculator RTL.
`timescale 1ns / 100ps

module heat_index_calculator_tb;
    import hic_pkg::*;

    localparam int LATENCY    = 14;
    localparam int DOG_LIMIT  = 5000;
    localparam int HOLD_LEN   = 200;
    localparam int RAND_ITEMS = 1450;

    typedef struct packed {
        logic signed [OUT_W-1:0] temp;
        logic signed [OUT_W-1:0] hi;
    } t_reading;

    typedef struct {
        logic                     unit;
        logic signed [TEMP_W-1:0] temp;
        logic        [RH_W-1:0]   rh;
        logic                     has_temp;
        logic signed [OUT_W-1:0]  temp_out;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     i_cfg_data;
    logic                     o_cfg_ready;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [TEMP_W-1:0] i_temp_celsius;
    logic        [RH_W-1:0]   i_rel_humidity;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [OUT_W-1:0]  o_temp_out;
    logic signed [OUT_W-1:0]  o_hindex;

    t_reading readings_due[$];
    logic     unit_f;
    logic     typed_pending;
    logic signed [OUT_W-1:0] typed_temp;
    int       errors;
    int       send_idle_pct;
    int       stall_pct;
    bit       hold_req;
    int       quiet_cycles;

    heat_index_calculator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_temp_celsius (i_temp_celsius),
        .i_rel_humidity (i_rel_humidity),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_temp_out     (o_temp_out),
        .o_hindex       (o_hindex)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Magnitude shift and division, rounding half away from zero
    function automatic longint shift_round(longint v, int s);
        longint unsigned m;
        m = v < 0 ? -v : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint div_round(longint v, longint d);
        longint unsigned m;
        m = v < 0 ? -v : v;
        m = (m + longint'(d) / 2) / d;
        return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp20(longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return v[OUT_W-1:0];
    endfunction

    // Heat index of one sample in the selected unit
    function automatic t_reading predict_reading(logic signed [TEMP_W-1:0] t,
                                                 logic [RH_W-1:0] rh, logic fahr);
        longint tc, h, f, f2, h2, fh, f2h, fh2, f2h2, hi, d, s, sum;
        longint unsigned num, r;
        t_reading res;
        tc = t;
        h = longint'({49'b0, rh}) << 8;
        f = div_round(9 * tc * 256, 5) + 32 * ONE16;
        f2 = shift_round(f * f, 16);
        h2 = shift_round(h * h, 16);
        fh = shift_round(f * h, 16);
        f2h = shift_round(f2 * h, 16);
        fh2 = shift_round(f * h2, 16);
        f2h2 = shift_round(f2 * h2, 16);
        hi = -K_C + shift_round(K_F * f, 32) + shift_round(K_H * h, 32)
           - shift_round(K_FH * fh, 32) - shift_round(K_F2 * f2, 32)
           - shift_round(K_H2 * h2, 32) + shift_round(K_F2H * f2h, 32)
           + shift_round(K_FH2 * fh2, 32) - shift_round(K_F2H2 * f2h2, 32);
        if (h < 13 * ONE16 && f >= 80 * ONE16 && f <= 110 * ONE16) begin
            d = f - 95 * ONE16;
            num = 17 * ONE16 - (d < 0 ? -d : d);
            r = (num << 16) / 17;
            s = int_sqrt(r);
            hi -= shift_round((13 * ONE16 - h) * s, 18);
        end else if (h > 85 * ONE16 && f > 80 * ONE16 && f < 87 * ONE16) begin
            hi += div_round((h - 85 * ONE16) * (87 * ONE16 - f), 50 * ONE16);
        end else if (f < 80 * ONE16) begin
            sum = f + 61 * ONE16 + div_round(6 * (f - 68 * ONE16), 5)
                + div_round(94 * h, 1000);
            hi = div_round(sum, 2);
        end
        if (fahr) begin
            res.temp = clamp20(shift_round(f, 8));
            res.hi = clamp20(shift_round(hi, 8));
        end else begin
            res.temp = clamp20(tc);
            res.hi = clamp20(shift_round(div_round(5 * (hi - 32 * ONE16), 9), 8));
        end
        return res;
    endfunction

    // Record an expectation for every input transfer
    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            e = predict_reading(i_temp_celsius, i_rel_humidity, unit_f);
            if (typed_pending) e.temp = typed_temp;
            readings_due.push_back(e);
        end
    end

    // Check every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (readings_due.size() == 0) begin
                $error("unexpected result temp_out=%0d hindex=%0d",
                       o_temp_out, o_hindex);
                errors++;
            end else begin
                e = readings_due.pop_front();
                if (o_temp_out !== e.temp) begin
                    $error("temp_out expected %0d got %0d", e.temp, o_temp_out);
                    errors++;
                end
                if (o_hindex !== e.hi) begin
                    $error("hindex expected %0d got %0d", e.hi, o_hindex);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= DOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 0;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Wait until all results are back and the pipe has emptied
    task automatic drain();
        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_unit(logic u);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= u;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        unit_f = u;
    endtask

    // Offer one sample, hold it until transferred, then maybe go idle
    task automatic send(logic signed [TEMP_W-1:0] t, logic [RH_W-1:0] rh);
        i_in_valid <= 1'b1;
        i_temp_celsius <= t;
        i_rel_humidity <= rh;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        logic signed [TEMP_W-1:0] t;
        logic [RH_W-1:0] rh;
        case ($urandom_range(3))
            0: t = TEMP_W'($urandom);
            default: t = TEMP_W'($urandom_range(12000, 4000));
        endcase
        case ($urandom_range(7))
            0: rh = RH_W'($urandom);
            1: rh = RH_W'($urandom_range(3500));
            2: rh = RH_W'($urandom_range(25600, 21500));
            default: rh = RH_W'($urandom_range(25600));
        endcase
        send(t, rh);
    endtask

    t_row table_rows[$];
    int   n;

    initial begin
        errors = 0;
        unit_f = 1'b0;
        typed_pending = 1'b0;
        typed_temp = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        quiet_cycles = 0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 1'b0;
        i_in_valid <= 1'b0;
        i_temp_celsius <= '0;
        i_rel_humidity <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Celsius rows: temperature passes through unchanged
        table_rows = '{
            '{0, 16'sd0,      15'd0,     1, 20'sd0},
            '{0, -16'sd32768, 15'd0,     1, -20'sd32768},
            '{0, 16'sd32767,  15'd32767, 1, 20'sd32767},
            '{0, 16'sd8960,   15'd0,     1, 20'sd8960},
            '{0, 16'sd8960,   15'd3327,  1, 20'sd8960},
            '{0, 16'sd6827,   15'd1000,  0, 20'sd0},
            '{0, 16'sd11093,  15'd2000,  0, 20'sd0},
            '{0, 16'sd11094,  15'd100,   0, 20'sd0},
            '{0, 16'sd7000,   15'd25600, 0, 20'sd0},
            '{0, 16'sd7822,   15'd32767, 0, 20'sd0},
            '{0, 16'sd6826,   15'd21761, 0, 20'sd0},
            '{0, 16'sd5000,   15'd12800, 0, 20'sd0},
            '{0, 16'sd2560,   15'd25600, 0, 20'sd0},
            // Fahrenheit rows: exact conversions typed in
            '{1, 16'sd0,      15'd12800, 1, 20'sd8192},
            '{1, 16'sd1280,   15'd0,     1, 20'sd10496},
            '{1, 16'sd8960,   15'd0,     1, 20'sd24320},
            '{1, -16'sd32768, 15'd0,     0, 20'sd0},
            '{1, 16'sd32767,  15'd32767, 0, 20'sd0},
            '{1, 16'sd32767,  15'd0,     0, 20'sd0},
            '{1, 16'sd8000,   15'd25600, 0, 20'sd0},
            '{1, 16'sd7500,   15'd22000, 0, 20'sd0},
            '{1, 16'sd9500,   15'd1500,  0, 20'sd0},
            '{1, 16'sd6000,   15'd32767, 0, 20'sd0}
        };

        // Walk the directed table, switching unit while idle
        foreach (table_rows[k]) begin
            if (table_rows[k].unit != unit_f) begin
                i_in_valid <= 1'b0;
                write_unit(table_rows[k].unit);
            end
            typed_pending <= table_rows[k].has_temp;
            typed_temp <= table_rows[k].temp_out;
            send(table_rows[k].temp, table_rows[k].rh);
        end
        i_in_valid <= 1'b0;
        typed_pending <= 1'b0;

        // Random phases over idling modes and both units
        for (int ph = 0; ph < 8; ph++) begin
            write_unit(ph[0]);
            case (ph / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 59; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 59; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            for (n = 0; n < RAND_ITEMS / 8; n++) begin
                if (ph == 0 && n == 40) hold_req = 1;
                if (ph == 1 && n == 90) begin
                    i_in_valid <= 1'b0;
                    while (readings_due.size() != 0) @(posedge i_clk);
                end
                if (ph == 4 && n == 60) hold_req = 1;
                send_random();
            end
            i_in_valid <= 1'b0;
        end

        stall_pct = 0;
        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/hic_pkg.sv
hdl/heat_index_calculator.sv
hdl/hic_checker.sv
tb/heat_index_calculator_tb.sv
